// ===== rtl/hebp_pkg.sv =====
// Package for the Huffman encoder bit packer.
// Holds item and byte-bundle types, function codes and fixed widths.
// No dependencies.
`default_nettype none

package hebp_pkg;

  localparam int WORD_W     = 32;
  localparam int LEN_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int PEND_W     = 7;
  localparam int CNT_W      = 3;
  localparam int MAX_BYTES  = 4;
  localparam int NBYTE_W    = 3;
  localparam int VBITS_W    = 4;
  localparam int SYMBOL_W   = 8;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [SYMBOL_W-1:0] symbol;
    logic [WORD_W-1:0]   code_bits;
    logic [LEN_W-1:0]    code_len;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               last;
    logic               padded_final;
    logic [VBITS_W-1:0] valid_bits;
  } out_item_t;

  // Up to four finished bytes made by one item, earliest in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [NBYTE_W-1:0]               count;
    logic                             pad;
    logic [VBITS_W-1:0]               pad_bits;
  } bundle_t;

endpackage

`default_nettype wire

// ===== rtl/hebp_code_table.sv =====
// Code table memory: code word and length per symbol, registered read.
// Length reads as zero until an entry is written. Uses hebp_pkg.
`default_nettype none

module hebp_code_table #(
  parameter int SYMBOL_COUNT = 256,
  parameter int IDX_W        = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic                         rd_en,
  input  wire logic [IDX_W-1:0]             addr,
  input  wire logic [hebp_pkg::WORD_W-1:0]  wr_word,
  input  wire logic [hebp_pkg::LEN_W-1:0]   wr_len,
  output logic      [hebp_pkg::WORD_W-1:0]  rd_word,
  output logic      [hebp_pkg::LEN_W-1:0]   rd_len
);

  logic [hebp_pkg::WORD_W+hebp_pkg::LEN_W-1:0] mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]                      loaded;
  logic [hebp_pkg::WORD_W+hebp_pkg::LEN_W-1:0] rd_q;
  logic                                         rd_loaded;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {wr_word, wr_len};
    end
    if (rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      rd_loaded <= 1'b0;
    end else begin
      if (wr_en) begin
        loaded[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_loaded <= loaded[addr];
      end
    end
  end

  assign rd_word = rd_q[hebp_pkg::WORD_W+hebp_pkg::LEN_W-1:hebp_pkg::LEN_W];
  assign rd_len  = rd_loaded ? rd_q[hebp_pkg::LEN_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== rtl/hebp_packer.sv =====
// Lookup stage and bit accumulator: merges a code into pending bits and
// cuts finished bytes into a bundle. Uses hebp_pkg.
`default_nettype none

module hebp_packer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         acc,
  input  wire logic [1:0]                   acc_func,
  input  wire logic                         acc_inr,
  input  wire logic [hebp_pkg::WORD_W-1:0]  rd_word,
  input  wire logic [hebp_pkg::LEN_W-1:0]   rd_len,
  input  wire logic                         push_ready,
  output logic                              ready,
  output logic                              push_valid,
  output hebp_pkg::bundle_t                 push_bundle
);

  localparam int WIN_W = hebp_pkg::WORD_W + hebp_pkg::PEND_W;
  localparam int LA_W  = WIN_W + 1;

  logic                           s1_valid;
  logic [1:0]                     s1_func;
  logic                           s1_inr;
  logic [hebp_pkg::PEND_W-1:0]    pend;
  logic [hebp_pkg::CNT_W-1:0]     pend_cnt;
  logic [hebp_pkg::PEND_W-1:0]    pend_next;
  logic [hebp_pkg::CNT_W-1:0]     pend_cnt_next;

  logic                           is_enc;
  logic                           is_flush;
  logic [hebp_pkg::LEN_W-1:0]     len;
  logic [hebp_pkg::WORD_W-1:0]    code_m;
  logic [WIN_W-1:0]               win;
  logic [hebp_pkg::LEN_W-1:0]     total;
  logic [LA_W-1:0]                la;
  logic [hebp_pkg::NBYTE_W-1:0]   nbytes;
  logic [hebp_pkg::CNT_W-1:0]     rem;
  logic [hebp_pkg::BYTE_W-1:0]    flush_byte;
  logic                           advance;

  assign is_enc   = (s1_func == hebp_pkg::FUNC_ENCODE);
  assign is_flush = (s1_func == hebp_pkg::FUNC_FLUSH);
  assign len      = (is_enc && s1_inr) ? rd_len : '0;

  // Barrel-shift pending bits up by the code length and drop the code in below.
  assign code_m = rd_word & ~({hebp_pkg::WORD_W{1'b1}} << len);
  assign win    = (WIN_W'(pend) << len) | WIN_W'(code_m);
  assign total  = hebp_pkg::LEN_W'(pend_cnt) + len;
  assign la     = {1'b0, win} << (hebp_pkg::LEN_W'(LA_W) - total);
  assign nbytes = total[hebp_pkg::LEN_W-1:hebp_pkg::CNT_W];
  assign rem    = total[hebp_pkg::CNT_W-1:0];

  assign flush_byte = hebp_pkg::BYTE_W'({1'b0, pend} <<
                      (4'(hebp_pkg::BYTE_W) - {1'b0, pend_cnt}));

  always_comb begin
    push_bundle = '0;
    push_valid  = 1'b0;
    if (s1_valid && is_enc && nbytes != '0) begin
      push_valid = 1'b1;
      for (int k = 0; k < hebp_pkg::MAX_BYTES; k++) begin
        push_bundle.bytes[k] = la[LA_W-1-hebp_pkg::BYTE_W*k -: hebp_pkg::BYTE_W];
      end
      push_bundle.count = nbytes;
    end else if (s1_valid && is_flush && pend_cnt != '0) begin
      push_valid             = 1'b1;
      push_bundle.bytes[0]   = flush_byte;
      push_bundle.count      = hebp_pkg::NBYTE_W'(1);
      push_bundle.pad        = 1'b1;
      push_bundle.pad_bits   = {1'b0, pend_cnt};
    end
  end

  always_comb begin
    pend_next     = pend;
    pend_cnt_next = pend_cnt;
    if (is_enc) begin
      pend_next     = win[hebp_pkg::PEND_W-1:0] & ~({hebp_pkg::PEND_W{1'b1}} << rem);
      pend_cnt_next = rem;
    end else if (is_flush) begin
      pend_next     = '0;
      pend_cnt_next = '0;
    end
  end

  assign advance = s1_valid && (!push_valid || push_ready);
  assign ready   = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pend     <= '0;
      pend_cnt <= '0;
    end else begin
      if (advance) begin
        pend     <= pend_next;
        pend_cnt <= pend_cnt_next;
      end
      if (ready) begin
        s1_valid <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_func <= acc_func;
      s1_inr  <= acc_inr;
    end
  end

`ifndef NO_ASSERTIONS
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (advance && is_flush) |=> (pend_cnt == '0))
    else $error("flush left pending bits");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_func) && $stable(pend_cnt)))
    else $error("stalled stage changed");

  a_bundle_size: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_bundle.count != '0 &&
                    push_bundle.count <= hebp_pkg::NBYTE_W'(hebp_pkg::MAX_BYTES)))
    else $error("bundle byte count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/hebp_out_queue.sv =====
// Output slot: holds one byte bundle and hands its bytes out one per
// transfer, marking the last one. Uses hebp_pkg.
`default_nettype none

module hebp_out_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire hebp_pkg::bundle_t push_bundle,
  output logic               push_ready,
  output logic               result_valid,
  input  wire logic          result_ready,
  output hebp_pkg::out_item_t result
);

  logic                          full;
  logic [1:0]                    idx;
  hebp_pkg::bundle_t             slot;
  logic                          at_last;
  logic                          fire;

  assign at_last      = ({1'b0, idx} == slot.count - hebp_pkg::NBYTE_W'(1));
  assign fire         = full && result_ready;
  assign push_ready   = !full || (fire && at_last);
  assign result_valid = full;

  always_comb begin
    result.out_byte     = slot.bytes[idx];
    result.last         = at_last;
    result.padded_final = slot.pad;
    result.valid_bits   = slot.pad ? slot.pad_bits : hebp_pkg::VBITS_W'(hebp_pkg::BYTE_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (push_valid && push_ready) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (at_last) begin
        full <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      slot <= push_bundle;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    full |-> ({1'b0, idx} < slot.count))
    else $error("byte index past bundle end");

  a_hold_until_drained: assert property (@(posedge clk) disable iff (rst)
    (full && !(fire && at_last)) |=> full)
    else $error("bundle dropped before last byte");

  a_pad_single: assert property (@(posedge clk) disable iff (rst)
    (full && slot.pad) |-> (result.last && result.valid_bits != '0 &&
                            result.valid_bits < hebp_pkg::VBITS_W'(hebp_pkg::BYTE_W)))
    else $error("padded byte not a lone partial byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/huffman_encoder_bit_packer_top.sv =====
// Huffman encoder bit packer, top level.
// Instantiates hebp_code_table, hebp_packer and hebp_out_queue; uses hebp_pkg.
//
// Input channel (item_valid / item_ready / item): func LOAD writes the code
// word and length of one symbol into the code table; ENCODE looks the symbol
// up and appends its code, most significant used bit first, to the pending
// bits; FLUSH zero-pads the pending bits to a byte and sends it as the final
// one. Output channel (result_valid / result_ready / result): one packed byte
// per transfer, earliest bit in bit 7, with last set on the final byte of an
// item and padded_final / valid_bits describing a flush byte.
// Order: an accepted item reads the table memory at its accept edge; the
// merge stage then adds the code to the pending bits and loads its bytes into
// the output slot once the slot can take them, and the bytes transfer from there.
// Throughput: one item per cycle while each item yields at most one byte and
// the receiver takes every byte; an item that yields several bytes holds the
// output slot until all have gone, as the output carries one byte per transfer.
// Reset: clears the pipeline, the output slot, the pending bits and the
// per-symbol loaded flags, so every symbol reads as length zero until loaded.
// When the receiver stalls, the slot holds its byte; the merge stage then
// holds one item and item_ready drops until the slot drains.
`default_nettype none

module huffman_encoder_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire hebp_pkg::in_item_t item,
  output logic                result_valid,
  input  wire logic           result_ready,
  output hebp_pkg::out_item_t result
);

  localparam int IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int EFF_MAX = (MAX_CODE_LEN < hebp_pkg::WORD_W) ? MAX_CODE_LEN
                                                               : hebp_pkg::WORD_W;
  localparam logic [hebp_pkg::SYMBOL_W:0] SYM_LIMIT = (hebp_pkg::SYMBOL_W+1)'(SYMBOL_COUNT);

  logic                         acc;
  logic                         in_range;
  logic [hebp_pkg::LEN_W-1:0]   len_sat;
  logic [hebp_pkg::WORD_W-1:0]  rd_word;
  logic [hebp_pkg::LEN_W-1:0]   rd_len;
  logic                         push_valid;
  logic                         push_ready;
  hebp_pkg::bundle_t            push_bundle;

  // Transfer on the input side; a symbol past the table is ignored.
  assign acc      = item_valid && item_ready;
  assign in_range = ({1'b0, item.symbol} < SYM_LIMIT);

  // Saturate loaded lengths to the code word and the configured maximum.
  assign len_sat = (item.code_len > hebp_pkg::LEN_W'(EFF_MAX))
                 ? hebp_pkg::LEN_W'(EFF_MAX) : item.code_len;

  hebp_code_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (acc && in_range && item.func == hebp_pkg::FUNC_LOAD),
    .rd_en   (acc && item.func == hebp_pkg::FUNC_ENCODE),
    .addr    (item.symbol[IDX_W-1:0]),
    .wr_word (item.code_bits),
    .wr_len  (len_sat),
    .rd_word (rd_word),
    .rd_len  (rd_len)
  );

  hebp_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .acc_func    (item.func),
    .acc_inr     (in_range),
    .rd_word     (rd_word),
    .rd_len      (rd_len),
    .push_ready  (push_ready),
    .ready       (item_ready),
    .push_valid  (push_valid),
    .push_bundle (push_bundle)
  );

  hebp_out_queue u_outq (
    .clk          (clk),
    .rst          (rst),
    .push_valid   (push_valid),
    .push_bundle  (push_bundle),
    .push_ready   (push_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== tb/tb_huffman_encoder_bit_packer_top.sv =====
// Self-checking testbench for huffman_encoder_bit_packer_top.
// Drives code loads, encodes and flushes and checks every packed byte against a
// bit-level predictor. Depends on hebp_pkg and the RTL top level only.
`timescale 1ns / 100ps

// Predicts the packed byte stream and holds the bytes still owed by the block.
class packed_byte_checker;
  localparam int CODE_LEN_MAX = 32;

  logic [hebp_pkg::WORD_W-1:0] code_word [256];
  logic [hebp_pkg::LEN_W-1:0]  code_len  [256];
  logic [hebp_pkg::PEND_W-1:0] pend_bits;
  int                          pend_cnt;
  hebp_pkg::out_item_t         owed_bytes [$];

  int mismatches;
  int bytes_checked;
  int n_loads, n_encodes, n_flushes, n_ignored;
  int n_padded, n_four_byte;

  function new();
    foreach (code_len[i]) begin
      code_len[i]  = '0;
      code_word[i] = '0;
    end
    pend_bits = '0;
    pend_cnt  = 0;
  endfunction

  // Update the table and accumulator for one accepted item; queue its bytes.
  function void note_item(hebp_pkg::in_item_t it);
    int          l;
    int          cnt;
    int          n;
    logic [7:0]  acc;
    logic [hebp_pkg::WORD_W-1:0] cw;
    hebp_pkg::out_item_t made [hebp_pkg::MAX_BYTES];
    n = 0;
    case (it.func)
      hebp_pkg::FUNC_LOAD: begin
        n_loads++;
        l = it.code_len;
        if (l > CODE_LEN_MAX) l = CODE_LEN_MAX;
        if (l > hebp_pkg::WORD_W) l = hebp_pkg::WORD_W;
        code_word[it.symbol] = it.code_bits;
        code_len[it.symbol]  = l[hebp_pkg::LEN_W-1:0];
      end
      hebp_pkg::FUNC_ENCODE: begin
        n_encodes++;
        acc = {1'b0, pend_bits};
        cnt = pend_cnt;
        cw  = code_word[it.symbol];
        l   = code_len[it.symbol];
        if (l > hebp_pkg::WORD_W) l = hebp_pkg::WORD_W;
        for (int i = l; i > 0; i--) begin
          acc = {acc[6:0], cw[i-1]};
          cnt++;
          if (cnt == hebp_pkg::BYTE_W) begin
            if (n < hebp_pkg::MAX_BYTES) begin
              made[n].out_byte     = acc;
              made[n].last         = 1'b0;
              made[n].padded_final = 1'b0;
              made[n].valid_bits   = 4'd8;
              n++;
            end
            acc = '0;
            cnt = 0;
          end
        end
        if (n > 0) made[n-1].last = 1'b1;
        if (n == hebp_pkg::MAX_BYTES) n_four_byte++;
        for (int k = 0; k < n; k++) owed_bytes.push_back(made[k]);
        pend_bits = acc[hebp_pkg::PEND_W-1:0];
        pend_cnt  = cnt;
      end
      hebp_pkg::FUNC_FLUSH: begin
        n_flushes++;
        if (pend_cnt != 0) begin
          made[0].out_byte     = {1'b0, pend_bits} << (hebp_pkg::BYTE_W - pend_cnt);
          made[0].last         = 1'b1;
          made[0].padded_final = 1'b1;
          made[0].valid_bits   = pend_cnt[hebp_pkg::VBITS_W-1:0];
          owed_bytes.push_back(made[0]);
          n_padded++;
        end
        pend_bits = '0;
        pend_cnt  = 0;
      end
      default: n_ignored++;
    endcase
  endfunction

  // Compare one transferred byte with the oldest one owed.
  function void check_byte(hebp_pkg::out_item_t got);
    hebp_pkg::out_item_t want;
    if (owed_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected byte %h last=%b pad=%b vbits=%0d",
                 got.out_byte, got.last, got.padded_final, got.valid_bits);
      return;
    end
    want = owed_bytes.pop_front();
    bytes_checked++;
    if (got.out_byte !== want.out_byte || got.last !== want.last ||
        got.padded_final !== want.padded_final || got.valid_bits !== want.valid_bits) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: byte %0d exp %h/%b/%b/%0d got %h/%b/%b/%0d", bytes_checked,
                 want.out_byte, want.last, want.padded_final, want.valid_bits,
                 got.out_byte, got.last, got.padded_final, got.valid_bits);
    end
  endfunction

  function int outstanding();
    return owed_bytes.size();
  endfunction
endclass

module tb_huffman_encoder_bit_packer_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 106;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  // Function code with no meaning; the block must ignore it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  hebp_pkg::in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  hebp_pkg::out_item_t result;

  packed_byte_checker sb = new();

  // Symbols whose table entry has been written; only these are encoded, since
  // the code word of an entry is undefined until its first load.
  bit       sym_loaded [256];
  logic [7:0] loaded_syms [$];

  int  items_sent   = 0;
  int  cycle_cnt    = 0;
  int  stall_cycles = 0;
  int  tx_burst     = 0;
  int  rx_burst     = 0;
  int  rx_wait      = 0;
  logic hold_off    = 1'b0;

  huffman_encoder_bit_packer_top #(
    .MAX_CODE_LEN(32),
    .SYMBOL_COUNT(256)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Draw the idle cycles before one transfer. Now and then start a burst of
  // back-to-back transfers so that stretches without idling occur too.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic hebp_pkg::in_item_t mk(logic [1:0] f, logic [7:0] sym,
                                            logic [hebp_pkg::WORD_W-1:0] bits,
                                            logic [hebp_pkg::LEN_W-1:0] len);
    hebp_pkg::in_item_t it;
    it.func      = f;
    it.symbol    = sym;
    it.code_bits = bits;
    it.code_len  = len;
    return it;
  endfunction

  // Offer one item after its idle gap and hold it until the transfer. Keep
  // valid high across back-to-back items so it is never lowered and raised in
  // the same step. While the receiver holds off, offer with no gaps.
  task automatic drive_item(input hebp_pkg::in_item_t it);
    int gap;
    gap = hold_off ? 0 : draw_gap(tx_burst);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic load_code(input logic [7:0] sym,
                           input logic [hebp_pkg::WORD_W-1:0] bits,
                           input logic [hebp_pkg::LEN_W-1:0] len);
    if (!sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    drive_item(mk(hebp_pkg::FUNC_LOAD, sym, bits, len));
  endtask

  // Code and length fields are unused by encode and flush; fill them anyway.
  task automatic encode_sym(input logic [7:0] sym);
    drive_item(mk(hebp_pkg::FUNC_ENCODE, sym, $urandom, 6'($urandom_range(0, 63))));
  endtask

  task automatic flush_acc();
    drive_item(mk(hebp_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63))));
  endtask

  // Receiver: check every transfer, then draw a stall before taking the next
  // byte. The long hold-off overrides the normal pattern.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_wait      = 0;
    end else begin
      if (result_valid && result_ready) sb.check_byte(result);
      if (hold_off) begin
        result_ready <= 1'b0;
      end else if (result_valid && result_ready) begin
        rx_wait = draw_gap(rx_burst);
        if (rx_wait != 0) begin
          result_ready <= 1'b0;
          rx_wait = rx_wait - 1;
        end
      end else if (!result_ready) begin
        if (rx_wait == 0) result_ready <= 1'b1;
        else rx_wait = rx_wait - 1;
      end
    end
  end

  // Back-pressure: once the random part is under way, hold the receiver off
  // for a long stretch so the output slot and merge stage fill and the input
  // stalls. Count the stalled input cycles for the summary.
  initial begin : pressure
    wait (items_sent >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) begin
      @(posedge clk);
      if (item_valid && !item_ready) stall_cycles++;
    end
    hold_off <= 1'b0;
  end

  // Watchdog: end the run if it takes far longer than any correct run could.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d bytes still owed", cycle_cnt, sb.outstanding());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int op;
    int len;
    logic [7:0] sym;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: widest and saturated lengths, zero length, byte boundaries
    // hit exactly, pad bytes with three, seven and one real bits, an empty flush
    // and the unused function code.
    load_code(8'h00, 32'hFFFF_FFFF, 6'd32);   // longest code, all ones
    load_code(8'hFF, 32'h0000_0000, 6'd63);   // length field all ones, saturates
    load_code(8'h55, 32'h0000_0005, 6'd3);
    load_code(8'hAA, 32'hA5A5_A5A5, 6'd0);    // written entry with zero length
    load_code(8'h01, 32'h0000_0001, 6'd1);
    load_code(8'h80, 32'h1234_5678, 6'd40);   // above the word width, saturates
    encode_sym(8'h55);                        // three bits pending
    encode_sym(8'h00);                        // 35 bits: four bytes, three pending
    encode_sym(8'hAA);                        // adds nothing
    flush_acc();                              // padded byte with three real bits
    flush_acc();                              // nothing pending: no byte
    encode_sym(8'hFF);                        // four zero bytes
    encode_sym(8'h01);                        // one bit pending
    drive_item(mk(FUNC_UNUSED, 8'hC3, $urandom, 6'h3F)); // unused function: ignored
    encode_sym(8'h80);                        // 33 bits: four bytes, one pending
    load_code(8'h55, 32'hFFFF_FF7F, 6'd7);    // reload and use at once
    encode_sym(8'h55);                        // exactly one byte, none pending
    encode_sym(8'h55);                        // seven pending
    encode_sym(8'h01);                        // completes a byte
    encode_sym(8'h55);                        // seven pending again
    flush_acc();                              // pad byte with seven real bits
    encode_sym(8'h01);
    flush_acc();                              // pad byte with one real bit

    // Random part: mostly encodes of loaded symbols, interleaved with code loads,
    // flushes and the odd ignored item.
    repeat (RANDOM_ITEMS) begin
      op = $urandom_range(0, 19);
      if (op < 4) begin
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = $urandom_range(33, 63);
          2, 3:    len = $urandom_range(13, 32);
          default: len = $urandom_range(1, 12);
        endcase
        sym = 8'($urandom_range(0, 255));
        load_code(sym, $urandom, len[hebp_pkg::LEN_W-1:0]);
      end else if (op < 17) begin
        encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
      end else if (op < 19) begin
        flush_acc();
      end else begin
        drive_item(mk(FUNC_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                      6'($urandom_range(0, 63))));
      end
    end
    flush_acc();
    item_valid <= 1'b0;

    // Drain: wait for every owed byte, then keep watching for stray bytes.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d items: %0d loads, %0d encodes, %0d flushes, %0d ignored; %0d bytes checked",
             items_sent, sb.n_loads, sb.n_encodes, sb.n_flushes, sb.n_ignored,
             sb.bytes_checked);
    $display("%0d padded final bytes, %0d four-byte encodes, input stalled %0d cycles on hold",
             sb.n_padded, sb.n_four_byte, stall_cycles);
    if (sb.outstanding() != 0)
      $display("ERROR: %0d expected bytes never arrived", sb.outstanding());
    if (sb.mismatches > 10)
      $display("%0d mismatches in total", sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
